>>> hw/rtl/running_sum_of_smallest_m_core_macros.svh
// Assertion macros for the heap controller of the smallest-m summing core.
`ifndef RUNNING_SUM_OF_SMALLEST_M_CORE_MACROS_SVH
`define RUNNING_SUM_OF_SMALLEST_M_CORE_MACROS_SVH

// Checks a property on every rising edge while out of reset.
`define RSSM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a property in the next cycle.
`define RSSM_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

>>> hw/rtl/rssm_pkg.sv
package rssm_pkg;

	// Default number of heap entries.
	localparam int CAPACITY_DEF = 1024;

	localparam int VALUE_W = 32;
	localparam int SUM_W = 43;
	localparam int KEEP_W = 11;
	localparam logic [KEEP_W-1:0] SEEN_MAX = 11'd2047;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic restart;
	} item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] smallest_sum;
		logic ready_res;
	} result_t;

	// Finished result handed from the heap controller to the output register.
	typedef struct packed {
		logic valid;
		result_t data;
	} res_xfer_t;

endpackage

>>> hw/rtl/running_sum_of_smallest_m_core.sv
// Sequence: an accepted item first evicts the root and sifts down once per entry above keep_count,
// then is placed: it sifts up one heap level at a time, replaces the maximum and sifts down, or is
// dropped when it does not enter a full heap or keep_count is 0.
// Throughput: one item at a time; the next item is taken in the cycle after the result is
// registered, and a stalled full output register holds the sequencer.
// Reset clears counts, sum and output valid, sets keep_count to 1, keeps heap memory as is.
module running_sum_of_smallest_m_core #(
	parameter int CAPACITY = rssm_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  rssm_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output rssm_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rssm_pkg::KEEP_W-1:0] cfg_data
);
	import rssm_pkg::*;

	logic [KEEP_W-1:0] keep_count_q;
	logic result_valid_q;
	result_t result_q;
	res_xfer_t res;
	logic slot_free;

	assign cfg_ready = 1'b1;
	assign slot_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			keep_count_q <= cfg_data;
		end
	end

	rssm_heap_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.keep_count(keep_count_q),
		.slot_free(slot_free),
		.res(res)
	);

	// Output register holds a result transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res.valid) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			result_q <= res.data;
		end
	end

endmodule

>>> hw/rtl/rssm_ram.sv
module rssm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hw/rtl/rssm_heap_ctrl.sv
`include "running_sum_of_smallest_m_core_macros.svh"

module rssm_heap_ctrl #(
	parameter int CAPACITY = rssm_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  rssm_pkg::item_t item,
	input  logic [rssm_pkg::KEEP_W-1:0] keep_count,
	input  logic slot_free,
	output rssm_pkg::res_xfer_t res
);
	import rssm_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int W2 = AW + 2;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_TRIM   = 4'd1;
	localparam logic [3:0] ST_POP_RD = 4'd2;
	localparam logic [3:0] ST_SD_RD  = 4'd3;
	localparam logic [3:0] ST_SD_CMP = 4'd4;
	localparam logic [3:0] ST_PLACE  = 4'd5;
	localparam logic [3:0] ST_RP_RD  = 4'd6;
	localparam logic [3:0] ST_SU_RD  = 4'd7;
	localparam logic [3:0] ST_SU_CMP = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] ret_q;
	logic [CW-1:0] held_q;
	logic [KEEP_W-1:0] seen_q;
	logic [SUM_W-1:0] sum_q;
	logic signed [VALUE_W-1:0] v_q;
	logic signed [VALUE_W-1:0] x_q;
	logic [AW-1:0] i_q;

	logic [CW-1:0] m;
	logic accept;
	logic we;
	logic [AW-1:0] waddr;
	logic [VALUE_W-1:0] wdata;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic [VALUE_W-1:0] rdata_a;
	logic [VALUE_W-1:0] rdata_b;
	logic signed [VALUE_W-1:0] rd_a;
	logic signed [VALUE_W-1:0] rd_b;
	logic [W2-1:0] c1;
	logic [W2-1:0] c2;
	logic [W2-1:0] held_w;
	logic pick_b;
	logic signed [VALUE_W-1:0] big;
	logic [AW-1:0] big_idx;
	logic [AW-1:0] parent;
	logic [KEEP_W-1:0] seen_base;

	rssm_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// Effective kept count saturates at the heap size.
	assign m = (int'(keep_count) >= CAPACITY) ? CW'(CAPACITY) : CW'(keep_count);
	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign rd_a = $signed(rdata_a);
	assign rd_b = $signed(rdata_b);

	// Heap index arithmetic for the current hole.
	assign c1 = {1'b0, i_q, 1'b1};
	assign c2 = c1 + W2'(1);
	assign held_w = W2'(held_q);
	assign pick_b = (c2 < held_w) && (rd_b > rd_a);
	assign big = pick_b ? rd_b : rd_a;
	assign big_idx = pick_b ? c2[AW-1:0] : c1[AW-1:0];
	assign parent = AW'((i_q - AW'(1)) >> 1);
	assign seen_base = item.restart ? '0 : seen_q;

	// Memory port control. Every read whose data is used is issued after any
	// write to the same entry, so the array needs no forwarding.
	always_comb begin
		we = 1'b0;
		waddr = i_q;
		wdata = x_q;
		raddr_a = '0;
		raddr_b = AW'(held_q - CW'(1));
		unique case (state_q)
			ST_SD_RD: begin
				raddr_a = c1[AW-1:0];
				raddr_b = c2[AW-1:0];
				we = (c1 >= held_w);
			end
			ST_SD_CMP: begin
				we = 1'b1;
				wdata = (big > x_q) ? big : x_q;
			end
			ST_SU_RD: begin
				raddr_a = parent;
				we = (i_q == '0);
			end
			ST_SU_CMP: begin
				we = 1'b1;
				wdata = (rd_a < x_q) ? rd_a : x_q;
			end
			default: begin
			end
		endcase
	end

	// Result hand-off to the output register.
	always_comb begin
		res.valid = (state_q == ST_DONE) && slot_free;
		res.data.smallest_sum = $signed(sum_q);
		res.data.ready_res = (int'(seen_q) >= int'(m));
	end

	// Sequencer: trim the heap to m, then insert, replace the maximum, or drop the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			held_q <= '0;
			seen_q <= '0;
			sum_q <= '0;
			v_q <= '0;
			x_q <= '0;
			i_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						v_q <= item.value;
						if (item.restart) begin
							held_q <= '0;
							sum_q <= '0;
						end
						seen_q <= (seen_base == SEEN_MAX) ? seen_base
							: seen_base + KEEP_W'(1);
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					state_q <= (held_q > m) ? ST_POP_RD : ST_PLACE;
				end
				ST_POP_RD: begin
					sum_q <= sum_q - SUM_W'(rd_a);
					held_q <= held_q - CW'(1);
					x_q <= rd_b;
					i_q <= '0;
					ret_q <= ST_TRIM;
					state_q <= (held_q == CW'(1)) ? ST_TRIM : ST_SD_RD;
				end
				ST_SD_RD: begin
					state_q <= (c1 >= held_w) ? ret_q : ST_SD_CMP;
				end
				ST_SD_CMP: begin
					if (big > x_q) begin
						i_q <= big_idx;
						state_q <= ST_SD_RD;
					end else begin
						state_q <= ret_q;
					end
				end
				ST_PLACE: begin
					if (held_q < m) begin
						i_q <= AW'(held_q);
						held_q <= held_q + CW'(1);
						sum_q <= sum_q + SUM_W'(v_q);
						x_q <= v_q;
						state_q <= ST_SU_RD;
					end else if (m == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RP_RD;
					end
				end
				ST_RP_RD: begin
					if (v_q < rd_a) begin
						sum_q <= sum_q + SUM_W'(v_q) - SUM_W'(rd_a);
						x_q <= v_q;
						i_q <= '0;
						ret_q <= ST_DONE;
						state_q <= ST_SD_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SU_RD: begin
					state_q <= (i_q == '0) ? ST_DONE : ST_SU_CMP;
				end
				ST_SU_CMP: begin
					if (rd_a < x_q) begin
						i_q <= parent;
						state_q <= ST_SU_RD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RSSM_ASSERT(a_held_bound, int'(held_q) <= CAPACITY, "heap holds more than its capacity")
	`RSSM_ASSERT_NEXT(a_accept_trim, accept, state_q == ST_TRIM, "accepted item did not start a trim")
	`RSSM_ASSERT(a_idle_no_write, !(we && state_q == ST_IDLE), "heap memory written while idle")
	`RSSM_ASSERT_NEXT(a_done_leaves, res.valid, state_q == ST_IDLE, "result sent but sequencer busy")

endmodule
